@@ design/stts_pkg.sv @@
// Package for the timer table scheduler: request/response types, codes.
// No dependencies.
package stts_pkg;
   localparam int TIMERS_DEFAULT = 16;

   typedef enum logic [2:0] {
      CMD_ARM_AT = 3'd0, CMD_ARM_IN = 3'd1, CMD_ARM_EVERY = 3'd2,
      CMD_DISCHARGE = 3'd3, CMD_UNWARP = 3'd4, CMD_RUN = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_OK = 3'd0, KIND_FULL = 3'd1, KIND_NOT_FOUND = 3'd2,
      KIND_FIRE = 3'd3, KIND_DELAY = 3'd4, KIND_NONE = 3'd5
   } kind_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] timer_key;
      logic [63:0] time_value;
      logic [63:0] now_us;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [15:0] fired_key;
      logic [63:0] delay_us;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SRCH_RD, ST_SRCH_CHK, ST_WALK_RD, ST_WALK_CHK,
      ST_COMP_WR, ST_EMIT, ST_REPLY, ST_FINAL
   } state_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction
endpackage

@@ design/stts_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module stts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ design/software_timer_table_scheduler.sv @@
// Timer table scheduler top level. Uses stts_pkg and stts_ram.
// One request at a time, accepted only while idle. Arm and discharge search
// the table entry by entry (a read step, then a compare step) up to the
// matching entry or the end of the table; unwarp walks every live entry with
// a read and a check step each; run walks every live entry with a read, a
// check and a compaction write step each, plus an emit step per fired timer.
// An accept step, a step to close the walk or search and a response step
// come on top, and any response stall lengthens these. The single read port
// of the entry memory is why entries are read one at a time. The table is
// compacted in place during that walk; no clearing pass exists after reset.
module software_timer_table_scheduler #(
   parameter int TIMERS = stts_pkg::TIMERS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stts_pkg::rsp_type rsp_data
);
   localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam int CW = $clog2(TIMERS + 1);
   localparam int EW = 16 + 64 + 64 + 1;

   stts_pkg::state_type state_ff, state_in;
   stts_pkg::req_type   req_ff, req_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in, wp_ff, wp_in;
   logic [63:0]   min_ff, min_in;
   logic          have_ff, have_in;
   stts_pkg::rsp_type rsp_ff, rsp_in;
   logic          rv_ff, rv_in;
   logic [EW-1:0] pend_ff, pend_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;

   stts_ram #(.WIDTH(EW), .DEPTH(TIMERS), .AW(AW)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   logic [15:0] e_key;
   logic [63:0] e_due, e_per;
   logic        e_arm;
   assign {e_key, e_due, e_per, e_arm} = rd_data;

   logic out_free;
   assign out_free = !rv_ff || !rsp_stall;
   assign req_stall = (state_ff != stts_pkg::ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;

   logic [63:0] nd, fd, ud;
   always_comb begin
      nd = stts_pkg::sat_add(e_due, e_per);
      fd = (nd < req_ff.now_us) ? stts_pkg::sat_add(req_ff.now_us, e_per) : nd;
      ud = stts_pkg::sat_add(req_ff.now_us, e_per);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stts_pkg::ST_IDLE:
            if (req_valid) begin
               if (req_data.cmd inside {stts_pkg::CMD_ARM_AT, stts_pkg::CMD_ARM_IN,
                     stts_pkg::CMD_ARM_EVERY, stts_pkg::CMD_DISCHARGE})
                  state_in = stts_pkg::ST_SRCH_RD;
               else if (req_data.cmd inside {stts_pkg::CMD_UNWARP, stts_pkg::CMD_RUN})
                  state_in = stts_pkg::ST_WALK_RD;
               else state_in = stts_pkg::ST_REPLY;
            end
         stts_pkg::ST_SRCH_RD:
            state_in = (idx_ff >= count_ff) ? stts_pkg::ST_REPLY : stts_pkg::ST_SRCH_CHK;
         stts_pkg::ST_SRCH_CHK:
            state_in = (e_key == req_ff.timer_key) ? stts_pkg::ST_REPLY
                                                    : stts_pkg::ST_SRCH_RD;
         stts_pkg::ST_WALK_RD:
            state_in = (idx_ff >= count_ff) ? stts_pkg::ST_FINAL : stts_pkg::ST_WALK_CHK;
         stts_pkg::ST_WALK_CHK:
            if (req_ff.cmd == stts_pkg::CMD_RUN && e_arm && e_due <= req_ff.now_us)
               state_in = stts_pkg::ST_EMIT;
            else if (req_ff.cmd == stts_pkg::CMD_RUN) state_in = stts_pkg::ST_COMP_WR;
            else state_in = stts_pkg::ST_WALK_RD;
         stts_pkg::ST_EMIT:
            if (out_free) state_in = stts_pkg::ST_COMP_WR;
         stts_pkg::ST_COMP_WR: state_in = stts_pkg::ST_WALK_RD;
         stts_pkg::ST_REPLY, stts_pkg::ST_FINAL:
            if (out_free) state_in = stts_pkg::ST_IDLE;
         default: state_in = stts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_in = req_ff; count_in = count_ff; idx_in = idx_ff; wp_in = wp_ff;
      min_in = min_ff; have_in = have_ff; pend_in = pend_ff;
      rsp_in = rsp_ff; rv_in = rv_ff && rsp_stall;
      wr_en = 1'b0; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data;
      rd_addr = idx_ff[AW-1:0];
      case (state_ff)
         stts_pkg::ST_IDLE:
            if (req_valid) begin
               req_in = req_data; idx_in = '0; wp_in = '0; have_in = 1'b0;
            end
         stts_pkg::ST_SRCH_CHK:
            if (e_key != req_ff.timer_key) idx_in = idx_ff + 1'b1;
         stts_pkg::ST_WALK_CHK: begin
            pend_in = rd_data;
            if (req_ff.cmd == stts_pkg::CMD_UNWARP) begin
               if (e_per != '0 && e_due < ud) begin
                  wr_en = 1'b1; wr_data = {e_key, ud, e_per, e_arm};
               end
               idx_in = idx_ff + 1'b1;
            end else if (e_arm && e_due <= req_ff.now_us) begin
               pend_in = {e_key, fd, e_per, e_per != '0};
            end
         end
         stts_pkg::ST_EMIT:
            if (out_free) begin
               rv_in = 1'b1;
               rsp_in = '{stts_pkg::KIND_FIRE, pend_ff[EW-1 -: 16], 64'd0, 1'b0};
            end
         stts_pkg::ST_COMP_WR: begin
            idx_in = idx_ff + 1'b1;
            if (pend_ff[0]) begin
               wr_en = 1'b1; wr_addr = wp_ff[AW-1:0]; wr_data = pend_ff;
               wp_in = wp_ff + 1'b1;
               if (!have_ff || pend_ff[128:65] < min_ff) min_in = pend_ff[128:65];
               have_in = 1'b1;
            end
         end
         stts_pkg::ST_REPLY:
            if (out_free) begin
               rv_in = 1'b1;
               rsp_in = '{stts_pkg::KIND_OK, 16'd0, 64'd0, 1'b1};
               if (req_ff.cmd inside {stts_pkg::CMD_ARM_AT, stts_pkg::CMD_ARM_IN,
                     stts_pkg::CMD_ARM_EVERY}) begin
                  if (idx_ff >= count_ff && count_ff == CW'(TIMERS))
                     rsp_in.result_kind = stts_pkg::KIND_FULL;
                  else begin
                     wr_en = 1'b1;
                     if (idx_ff >= count_ff) count_in = count_ff + 1'b1;
                     if (req_ff.cmd == stts_pkg::CMD_ARM_AT)
                        wr_data = {req_ff.timer_key, req_ff.time_value, 64'd0, 1'b1};
                     else
                        wr_data = {req_ff.timer_key,
                           stts_pkg::sat_add(req_ff.now_us, req_ff.time_value),
                           (req_ff.cmd == stts_pkg::CMD_ARM_EVERY) ?
                              req_ff.time_value : 64'd0, 1'b1};
                  end
               end else if (req_ff.cmd == stts_pkg::CMD_DISCHARGE) begin
                  if (idx_ff >= count_ff) rsp_in.result_kind = stts_pkg::KIND_NOT_FOUND;
                  else begin
                     wr_en = 1'b1; wr_data = {e_key, e_due, e_per, 1'b0};
                  end
               end
            end
         stts_pkg::ST_FINAL:
            if (out_free) begin
               rv_in = 1'b1;
               rsp_in = '{stts_pkg::KIND_OK, 16'd0, 64'd0, 1'b1};
               if (req_ff.cmd == stts_pkg::CMD_RUN) begin
                  count_in = wp_ff;
                  if (!have_ff) rsp_in.result_kind = stts_pkg::KIND_NONE;
                  else begin
                     rsp_in.result_kind = stts_pkg::KIND_DELAY;
                     rsp_in.delay_us = (min_ff > req_ff.now_us) ?
                        min_ff - req_ff.now_us : 64'd0;
                  end
               end
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stts_pkg::ST_IDLE; count_ff <= '0; rv_ff <= 1'b0;
         idx_ff <= '0; wp_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rv_ff <= rv_in;
         idx_ff <= idx_in; wp_ff <= wp_in;
      end
      req_ff <= req_in; min_ff <= min_in;
      have_ff <= have_in; pend_ff <= pend_in; rsp_ff <= rsp_in;
   end

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TIMERS)) else $error("entry count above table size");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_stall |=> rv_ff && $stable(rsp_ff)) else $error("response lost");
   a_wp: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= idx_ff) else $error("compaction overtook read");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != stts_pkg::ST_IDLE |-> req_stall) else $error("accept while busy");
endmodule

@@ dv/software_timer_table_scheduler_checker.sv @@
// Checker for the timer table scheduler: watches both channels, keeps its own
// copy of the timer table and compares every response. Depends on stts_pkg.
`timescale 1ns / 1ps
module software_timer_table_scheduler_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  stts_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  stts_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   localparam int N = stts_pkg::TIMERS_DEFAULT;

   logic [15:0] tbl_key[N];
   logic [63:0] tbl_due[N];
   logic [63:0] tbl_period[N];
   logic        tbl_armed[N];
   int          tbl_count;
   stts_pkg::rsp_type want_q[$];

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   function automatic stts_pkg::rsp_type mk(stts_pkg::kind_type k, logic [15:0] key,
                                            logic [63:0] d, logic l);
      stts_pkg::rsp_type r;
      r.result_kind = k;
      r.fired_key = key;
      r.delay_us = d;
      r.last = l;
      return r;
   endfunction

   function automatic int find_key(logic [15:0] key);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_key[i] == key) return i;
      return -1;
   endfunction

   task automatic schedule_request(stts_pkg::req_type rq);
      int idx;
      int j;
      logic [63:0] s;
      logic [63:0] mn;
      case (rq.cmd)
         stts_pkg::CMD_ARM_AT, stts_pkg::CMD_ARM_IN, stts_pkg::CMD_ARM_EVERY: begin
            idx = find_key(rq.timer_key);
            if (idx < 0 && tbl_count >= N) begin
               want_q.push_back(mk(stts_pkg::KIND_FULL, 16'd0, 64'd0, 1'b1));
            end else begin
               if (idx < 0) begin
                  idx = tbl_count;
                  tbl_count++;
                  tbl_key[idx] = rq.timer_key;
               end
               if (rq.cmd == stts_pkg::CMD_ARM_AT) begin
                  tbl_period[idx] = 64'd0;
                  tbl_due[idx] = rq.time_value;
               end else begin
                  tbl_period[idx] = (rq.cmd == stts_pkg::CMD_ARM_EVERY) ?
                     rq.time_value : 64'd0;
                  tbl_due[idx] = add_sat(rq.now_us, rq.time_value);
               end
               tbl_armed[idx] = 1'b1;
               want_q.push_back(mk(stts_pkg::KIND_OK, 16'd0, 64'd0, 1'b1));
            end
         end
         stts_pkg::CMD_DISCHARGE: begin
            idx = find_key(rq.timer_key);
            if (idx < 0) begin
               want_q.push_back(mk(stts_pkg::KIND_NOT_FOUND, 16'd0, 64'd0, 1'b1));
            end else begin
               tbl_armed[idx] = 1'b0;
               want_q.push_back(mk(stts_pkg::KIND_OK, 16'd0, 64'd0, 1'b1));
            end
         end
         stts_pkg::CMD_UNWARP: begin
            for (int i = 0; i < tbl_count; i++)
               if (tbl_period[i] != 0) begin
                  s = add_sat(rq.now_us, tbl_period[i]);
                  if (tbl_due[i] < s) tbl_due[i] = s;
               end
            want_q.push_back(mk(stts_pkg::KIND_OK, 16'd0, 64'd0, 1'b1));
         end
         stts_pkg::CMD_RUN: begin
            if (tbl_count == 0) begin
               want_q.push_back(mk(stts_pkg::KIND_NONE, 16'd0, 64'd0, 1'b1));
            end else begin
               for (int i = 0; i < tbl_count; i++) begin
                  if (tbl_armed[i] && tbl_due[i] <= rq.now_us) begin
                     want_q.push_back(mk(stts_pkg::KIND_FIRE, tbl_key[i], 64'd0, 1'b0));
                     tbl_armed[i] = 1'b0;
                     if (tbl_period[i] != 0) begin
                        tbl_armed[i] = 1'b1;
                        tbl_due[i] = add_sat(tbl_due[i], tbl_period[i]);
                        if (tbl_due[i] < rq.now_us)
                           tbl_due[i] = add_sat(rq.now_us, tbl_period[i]);
                     end
                  end
               end
               j = 0;
               for (int i = 0; i < tbl_count; i++)
                  if (tbl_armed[i]) begin
                     tbl_key[j] = tbl_key[i];
                     tbl_due[j] = tbl_due[i];
                     tbl_period[j] = tbl_period[i];
                     tbl_armed[j] = 1'b1;
                     j++;
                  end
               tbl_count = j;
               if (j == 0) begin
                  want_q.push_back(mk(stts_pkg::KIND_NONE, 16'd0, 64'd0, 1'b1));
               end else begin
                  mn = tbl_due[0];
                  for (int i = 1; i < j; i++)
                     if (tbl_due[i] < mn) mn = tbl_due[i];
                  want_q.push_back(mk(stts_pkg::KIND_DELAY, 16'd0,
                     (mn > rq.now_us) ? mn - rq.now_us : 64'd0, 1'b1));
               end
            end
         end
         default: want_q.push_back(mk(stts_pkg::KIND_OK, 16'd0, 64'd0, 1'b1));
      endcase
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] exp);
      $display("mismatch %s: got %0h expected %0h", what, got, exp);
      fail_count++;
   endtask

   always @(posedge clock) begin
      stts_pkg::rsp_type w;
      if (reset) begin
         tbl_count = 0;
         want_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (want_q.size() == 0) begin
               report("unexpected response", rsp_data.delay_us, 64'd0);
            end else begin
               w = want_q.pop_front();
               if (rsp_data.result_kind !== w.result_kind)
                  report("result_kind", 64'(rsp_data.result_kind), 64'(w.result_kind));
               if (rsp_data.fired_key !== w.fired_key)
                  report("fired_key", 64'(rsp_data.fired_key), 64'(w.fired_key));
               if (rsp_data.delay_us !== w.delay_us)
                  report("delay_us", rsp_data.delay_us, w.delay_us);
               if (rsp_data.last !== w.last)
                  report("last", 64'(rsp_data.last), 64'(w.last));
            end
         end
         if (req_valid && !req_stall) schedule_request(req_data);
      end
      pending_count = want_q.size();
   end
endmodule

@@ dv/software_timer_table_scheduler_tb.sv @@
// Testbench top for the timer table scheduler: drives directed and random
// requests with bursty gaps and a stalling receiver. Depends on stts_pkg, the
// block and software_timer_table_scheduler_checker.
`timescale 1ns / 1ps
module software_timer_table_scheduler_tb;
   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   stts_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   stts_pkg::rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      burst_left;
   logic [63:0] now_base;
   bit      stall_mode;

   software_timer_table_scheduler DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   software_timer_table_scheduler_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("software_timer_table_scheduler_tb NOT OK");
      $finish;
   end

   // receiver stalls in runs, with stall-free phases between them
   initial begin
      rsp_stall = 0;
      stall_mode = 0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
         rsp_stall <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b0;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send_request(logic [2:0] cmd, logic [15:0] key,
                               logic [63:0] tv, logic [63:0] now);
      if (burst_left == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 8);
      end
      req_valid <= 1;
      req_data <= '{cmd: cmd, timer_key: key, time_value: tv, now_us: now};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
      if (burst_left == 0) req_valid <= 0;
   endtask

   task automatic random_request();
      logic [2:0]  cmd;
      logic [15:0] key;
      logic [63:0] tv;
      int          r;
      r = $urandom_range(0, 99);
      now_base = now_base + 64'($urandom_range(0, 500));
      key = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 19));
      case ($urandom_range(0, 3))
         0: tv = 64'($urandom_range(0, 1000));
         1: tv = now_base + 64'($urandom_range(0, 1500));
         2: tv = rand64();
         default: tv = ($urandom_range(0, 2) == 0) ? 64'd0 : 64'($urandom_range(1, 300));
      endcase
      if (r < 20) cmd = stts_pkg::CMD_ARM_AT;
      else if (r < 35) cmd = stts_pkg::CMD_ARM_IN;
      else if (r < 55) cmd = stts_pkg::CMD_ARM_EVERY;
      else if (r < 67) cmd = stts_pkg::CMD_DISCHARGE;
      else if (r < 74) cmd = stts_pkg::CMD_UNWARP;
      else if (r < 97) cmd = stts_pkg::CMD_RUN;
      else cmd = 3'($urandom_range(6, 7));
      send_request(cmd, key,
         (cmd == stts_pkg::CMD_ARM_AT && tv < 1000) ? now_base + tv : tv,
         ($urandom_range(0, 19) == 0) ? rand64() : now_base);
   endtask

   initial begin
      int wait_cycles;
      burst_left = 0;
      now_base = 1000;
      req_valid = 0;
      req_data = '0;
      reset = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send_request(stts_pkg::CMD_RUN, 0, 0, 0);
      send_request(stts_pkg::CMD_DISCHARGE, 16'hFFFF, 0, 0);
      send_request(stts_pkg::CMD_ARM_AT, 16'h0000, 64'd5, 0);
      send_request(stts_pkg::CMD_ARM_IN, 16'hFFFF, '1, '1);
      send_request(stts_pkg::CMD_ARM_EVERY, 16'h1234, 64'd0, 64'd10);
      send_request(stts_pkg::CMD_ARM_EVERY, 16'h5555, 64'd3, 64'd0);
      send_request(stts_pkg::CMD_ARM_EVERY, 16'hAAAA, '1, 64'd1);
      send_request(stts_pkg::CMD_DISCHARGE, 16'h0000, 0, 0);
      send_request(stts_pkg::CMD_ARM_AT, 16'h0000, 64'd7, 0);
      send_request(stts_pkg::CMD_UNWARP, 0, 0, 64'd100);
      send_request(stts_pkg::CMD_RUN, 0, 0, 64'd100);
      send_request(stts_pkg::CMD_RUN, 0, 0, 64'd1000);
      send_request(3'd6, 16'hFFFF, '1, '1);
      send_request(3'd7, 0, 0, 0);
      for (int i = 0; i < 17; i++)
         send_request(stts_pkg::CMD_ARM_AT, 16'(16'h100 + i), '1, 0);
      send_request(stts_pkg::CMD_DISCHARGE, 16'h0101, 0, 0);
      send_request(stts_pkg::CMD_RUN, 0, 0, '1);
      send_request(stts_pkg::CMD_RUN, 0, 0, '1);

      for (int n = 0; n < 116; n++) random_request();
      req_valid <= 0;

      while (pending_count != 0) @(posedge clock);
      wait_cycles = 0;
      while (wait_cycles < 100) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (fail_count == 0)
         $display("software_timer_table_scheduler_tb OK");
      else
         $display("software_timer_table_scheduler_tb NOT OK");
      $finish;
   end
endmodule
